// ===== rtl/trr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trr_pkg
// shared types and constants of the timeslice reorder release unit
// ----------------------------------------------------------------------------
package trr_pkg;

    localparam int HOLD_DEPTH = 16;
    localparam int GAP_DEPTH  = 16;
    localparam int HOLD_AW    = $clog2(HOLD_DEPTH);
    localparam int GAP_AW     = $clog2(GAP_DEPTH);
    localparam int GAP_FW     = GAP_AW + 1;

    typedef enum logic [1:0] {
        MODE_FULL = 2'd0,
        MODE_MISS = 2'd1,
        MODE_EOF  = 2'd2,
        MODE_STOP = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        KIND_FULL   = 2'd0,
        KIND_EMPTY  = 2'd1,
        KIND_FINISH = 2'd2,
        KIND_DROP   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLASS,
        ST_SCAN,
        ST_HSEL,
        ST_GAP,
        ST_FIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        mode_t       mode;
        logic [31:0] ts_index;
        logic [15:0] payload_tag;
        logic [31:0] total_expected;
    } item_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] out_index;
        logic [15:0] out_tag;
        logic [31:0] full_released;
        logic [31:0] missed_released;
    } result_t;

endpackage

// ===== rtl/timeslice_reorder_release_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timeslice_reorder_release_unit
// puts numbered timeslices back in index order and releases them
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | content
//  s_      | in  | tvalid / tready    | tuser mode, tdata index, tag, total
//  m_      | out | tvalid / tready    | tuser kind, tdata index, tag, counts,
//          |     |                    | tlast on the final word of an input
//
//  an input word passes through the command queue and the item register,
//  then is classified; each release attempt walks the hold table one entry
//  a cycle, then checks for the next index among the held entries, a hold
//  release walking again; else stale gap heads are dropped and a gap
//  release walks again; the attempt that finds nothing closes through
//  ST_FIN and ST_DONE (end-of-data and stop skip the walk)
//  one output word is held back inside so its tlast is known; the output
//  register lets the engine move on while the sink stalls
//  rst_n clears counters, valid bits and queue pointers at once
// ----------------------------------------------------------------------------
module timeslice_reorder_release_unit
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [79:0]   s_tdata,   // ts_index, payload_tag, total_expected
    input  logic [1:0]    s_tuser,   // mode
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [111:0]  m_tdata,   // out_index, out_tag, full_released,
                                     // missed_released
    output logic [1:0]    m_tuser,   // kind
    output logic          m_tlast
);

    trr_pkg::item_t   in_item;
    trr_pkg::item_t   cmd_item;
    trr_pkg::result_t res;
    logic             cmd_valid;
    logic             cmd_pop;

    // unpack the input word into the item record
    always_comb
    begin
        in_item.mode           = trr_pkg::mode_t'(s_tuser);
        in_item.ts_index       = s_tdata[31:0];
        in_item.payload_tag    = s_tdata[47:32];
        in_item.total_expected = s_tdata[79:48];
    end

    // front: queue decouples the source from the release engine
    trr_cmd_fifo u_cmd_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .out_valid (cmd_valid),
        .out_pop   (cmd_pop),
        .out_item  (cmd_item)
    );

    // back: hold table, gap queue and release sequencing
    trr_engine u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd_item  (cmd_item),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res_data  (res),
        .res_last  (m_tlast)
    );

    // pack the result word
    assign m_tuser = res.kind;
    assign m_tdata = {res.missed_released, res.full_released, res.out_tag, res.out_index};

endmodule

// ===== rtl/trr_cmd_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trr_cmd_fifo
// two-entry queue between the input side and the release engine
// ----------------------------------------------------------------------------
module trr_cmd_fifo
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  trr_pkg::item_t in_item,
    output logic           out_valid,
    input  logic           out_pop,
    output trr_pkg::item_t out_item
);

    trr_pkg::item_t slot_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     cnt_reg, cnt_next;
    logic           push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_item  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== rtl/trr_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trr_engine
// classifies items, keeps hold table and gap queue, runs release sequences
// ----------------------------------------------------------------------------
module trr_engine
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_pop,
    input  trr_pkg::item_t   cmd_item,
    output logic             res_valid,
    input  logic             res_ready,
    output trr_pkg::result_t res_data,
    output logic             res_last
);

    localparam logic [trr_pkg::HOLD_AW-1:0] HOLD_LAST = trr_pkg::HOLD_AW'(trr_pkg::HOLD_DEPTH - 1);
    localparam logic [trr_pkg::GAP_AW-1:0]  GAP_LAST  = trr_pkg::GAP_AW'(trr_pkg::GAP_DEPTH - 1);
    localparam logic [trr_pkg::GAP_FW-1:0]  GAP_FULL  = trr_pkg::GAP_FW'(trr_pkg::GAP_DEPTH);

    trr_pkg::state_t  state_reg, state_next;
    trr_pkg::item_t   item_reg, item_next;
    logic [31:0]      last_rel_reg, last_rel_next;
    logic [31:0]      full_reg, full_next;
    logic [31:0]      missed_reg, missed_next;
    logic             eof_reg, eof_next;
    logic [31:0]      fin_idx_reg, fin_idx_next;
    logic [31:0]      fin_tot_reg, fin_tot_next;
    logic             finished_reg, finished_next;

    logic [trr_pkg::HOLD_DEPTH-1:0] held_valid_reg, held_valid_next;
    logic [31:0]                    held_index_reg [trr_pkg::HOLD_DEPTH];
    logic [15:0]                    held_tag_reg   [trr_pkg::HOLD_DEPTH];
    logic                           hold_wr;

    logic [31:0]                gap_mem_reg [trr_pkg::GAP_DEPTH];
    logic [trr_pkg::GAP_AW-1:0] gap_head_reg, gap_head_next;
    logic [trr_pkg::GAP_AW-1:0] gap_tail_reg, gap_tail_next;
    logic [trr_pkg::GAP_FW-1:0] gap_fill_reg, gap_fill_next;
    logic                       gap_push, gap_pop;

    logic [trr_pkg::HOLD_AW-1:0] scan_ptr_reg, scan_ptr_next;
    logic                        best_v_reg, best_v_next;
    logic [31:0]                 best_idx_reg, best_idx_next;
    logic [trr_pkg::HOLD_AW-1:0] best_slot_reg, best_slot_next;

    logic             pend_v_reg, pend_v_next;
    trr_pkg::result_t pend_reg, pend_next;
    logic             out_v_reg, out_v_next;
    trr_pkg::result_t out_reg, out_next;
    logic             out_last_reg, out_last_next;

    logic             emit_req, can_out, can_emit, do_emit, flush;
    trr_pkg::result_t emit_res;

    logic [31:0]                 want, head;
    logic                        released_any, imm, stale, dup, slot_found;
    logic [trr_pkg::HOLD_AW-1:0] free_slot;

    assign res_valid = out_v_reg;
    assign res_data  = out_reg;
    assign res_last  = out_last_reg;

    assign want         = last_rel_reg + 32'd1;
    assign head         = gap_mem_reg[gap_head_reg];
    assign released_any = (full_reg != 32'd0) || (missed_reg != 32'd0);
    assign imm          = (item_reg.ts_index == want) ||
                          ((last_rel_reg == 32'd0) && (full_reg == 32'd0) &&
                           (item_reg.ts_index == 32'd0));
    assign stale        = released_any && (item_reg.ts_index <= last_rel_reg);

    // parallel match and first-free search over the hold table
    always_comb
    begin
        dup        = 1'b0;
        slot_found = 1'b0;
        free_slot  = '0;
        for (int i = 0; i < trr_pkg::HOLD_DEPTH; i++)
        begin
            if (held_valid_reg[i] && (held_index_reg[i] == item_reg.ts_index))
            begin
                dup = 1'b1;
            end
            if (!held_valid_reg[i] && !slot_found)
            begin
                slot_found = 1'b1;
                free_slot  = trr_pkg::HOLD_AW'(i);
            end
        end
    end

    assign can_out  = !out_v_reg || res_ready;
    assign can_emit = !pend_v_reg || can_out;
    assign do_emit  = emit_req && can_emit;

    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        last_rel_next   = last_rel_reg;
        full_next       = full_reg;
        missed_next     = missed_reg;
        eof_next        = eof_reg;
        fin_idx_next    = fin_idx_reg;
        fin_tot_next    = fin_tot_reg;
        finished_next   = finished_reg;
        held_valid_next = held_valid_reg;
        hold_wr         = 1'b0;
        gap_push        = 1'b0;
        gap_pop         = 1'b0;
        scan_ptr_next   = scan_ptr_reg;
        best_v_next     = best_v_reg;
        best_idx_next   = best_idx_reg;
        best_slot_next  = best_slot_reg;
        cmd_pop         = 1'b0;
        emit_req        = 1'b0;
        emit_res        = '{trr_pkg::KIND_DROP, item_reg.ts_index, 16'd0, full_reg, missed_reg};
        flush           = 1'b0;

        case (state_reg)
            trr_pkg::ST_IDLE:
            begin
                cmd_pop = 1'b1;
                if (cmd_valid)
                begin
                    item_next  = cmd_item;
                    // after finish every word is swallowed
                    state_next = finished_reg ? trr_pkg::ST_IDLE : trr_pkg::ST_CLASS;
                end
            end
            trr_pkg::ST_CLASS:
            begin
                case (item_reg.mode)
                    trr_pkg::MODE_FULL:
                    begin
                        if (imm)
                        begin
                            emit_req = 1'b1;
                            emit_res = '{trr_pkg::KIND_FULL, item_reg.ts_index,
                                         item_reg.payload_tag, full_reg + 32'd1, missed_reg};
                            if (can_emit)
                            begin
                                last_rel_next = item_reg.ts_index;
                                full_next     = full_reg + 32'd1;
                            end
                        end
                        else if (stale || dup || !slot_found)
                        begin
                            emit_req = 1'b1;
                            emit_res.out_tag = item_reg.payload_tag;
                        end
                        else
                        begin
                            hold_wr                    = 1'b1;
                            held_valid_next[free_slot] = 1'b1;
                        end
                        if (!emit_req || can_emit)
                        begin
                            state_next    = trr_pkg::ST_SCAN;
                            scan_ptr_next = '0;
                            best_v_next   = 1'b0;
                        end
                    end
                    trr_pkg::MODE_MISS:
                    begin
                        if (stale || (gap_fill_reg >= GAP_FULL))
                        begin
                            emit_req = 1'b1;
                        end
                        else
                        begin
                            gap_push = 1'b1;
                        end
                        if (!emit_req || can_emit)
                        begin
                            state_next    = trr_pkg::ST_SCAN;
                            scan_ptr_next = '0;
                            best_v_next   = 1'b0;
                        end
                    end
                    trr_pkg::MODE_EOF:
                    begin
                        eof_next     = 1'b1;
                        fin_idx_next = item_reg.ts_index;
                        fin_tot_next = item_reg.total_expected;
                        state_next   = trr_pkg::ST_FIN;
                    end
                    default:
                    begin
                        emit_req = 1'b1;
                        emit_res = '{trr_pkg::KIND_FINISH, last_rel_reg, 16'd0,
                                     full_reg, missed_reg};
                        if (can_emit)
                        begin
                            finished_next = 1'b1;
                            state_next    = trr_pkg::ST_DONE;
                        end
                    end
                endcase
            end
            trr_pkg::ST_SCAN:
            begin
                // one hold entry per cycle, keeping the smallest valid index
                if (held_valid_reg[scan_ptr_reg] &&
                    (!best_v_reg || (held_index_reg[scan_ptr_reg] < best_idx_reg)))
                begin
                    best_v_next    = 1'b1;
                    best_idx_next  = held_index_reg[scan_ptr_reg];
                    best_slot_next = scan_ptr_reg;
                end
                if (scan_ptr_reg == HOLD_LAST)
                begin
                    state_next = trr_pkg::ST_HSEL;
                end
                else
                begin
                    scan_ptr_next = scan_ptr_reg + 1'b1;
                end
            end
            trr_pkg::ST_HSEL:
            begin
                if (best_v_reg && (best_idx_reg == want))
                begin
                    emit_req = 1'b1;
                    emit_res = '{trr_pkg::KIND_FULL, want, held_tag_reg[best_slot_reg],
                                 full_reg + 32'd1, missed_reg};
                    if (can_emit)
                    begin
                        held_valid_next[best_slot_reg] = 1'b0;
                        last_rel_next = want;
                        full_next     = full_reg + 32'd1;
                        state_next    = trr_pkg::ST_SCAN;
                        scan_ptr_next = '0;
                        best_v_next   = 1'b0;
                    end
                end
                else
                begin
                    state_next = trr_pkg::ST_GAP;
                end
            end
            trr_pkg::ST_GAP:
            begin
                if ((gap_fill_reg != '0) && released_any && (head <= last_rel_reg))
                begin
                    // stale head goes away silently
                    gap_pop = 1'b1;
                end
                else if ((gap_fill_reg != '0) && (head == want))
                begin
                    emit_req = 1'b1;
                    emit_res = '{trr_pkg::KIND_EMPTY, want, 16'd0,
                                 full_reg, missed_reg + 32'd1};
                    if (can_emit)
                    begin
                        gap_pop       = 1'b1;
                        last_rel_next = want;
                        missed_next   = missed_reg + 32'd1;
                        state_next    = trr_pkg::ST_SCAN;
                        scan_ptr_next = '0;
                        best_v_next   = 1'b0;
                    end
                end
                else
                begin
                    state_next = trr_pkg::ST_FIN;
                end
            end
            trr_pkg::ST_FIN:
            begin
                if (!finished_reg && eof_reg && (last_rel_reg == fin_idx_reg) &&
                    (full_reg == fin_tot_reg))
                begin
                    emit_req = 1'b1;
                    emit_res = '{trr_pkg::KIND_FINISH, last_rel_reg, 16'd0,
                                 full_reg, missed_reg};
                    if (can_emit)
                    begin
                        finished_next = 1'b1;
                        state_next    = trr_pkg::ST_DONE;
                    end
                end
                else
                begin
                    state_next = trr_pkg::ST_DONE;
                end
            end
            trr_pkg::ST_DONE:
            begin
                // the held-back word closes the sequence with last set
                if (!pend_v_reg)
                begin
                    state_next = trr_pkg::ST_IDLE;
                end
                else if (can_out)
                begin
                    flush      = 1'b1;
                    state_next = trr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = trr_pkg::ST_IDLE;
            end
        endcase
    end

    // one word is held back so its last flag is known before it leaves
    always_comb
    begin
        out_v_next    = out_v_reg && !res_ready;
        out_next      = out_reg;
        out_last_next = out_last_reg;
        pend_v_next   = pend_v_reg;
        pend_next     = pend_reg;
        if (do_emit)
        begin
            if (pend_v_reg)
            begin
                out_v_next    = 1'b1;
                out_next      = pend_reg;
                out_last_next = 1'b0;
            end
            pend_v_next = 1'b1;
            pend_next   = emit_res;
        end
        else if (flush)
        begin
            out_v_next    = 1'b1;
            out_next      = pend_reg;
            out_last_next = 1'b1;
            pend_v_next   = 1'b0;
        end
    end

    always_comb
    begin
        gap_head_next = gap_head_reg;
        gap_tail_next = gap_tail_reg;
        gap_fill_next = gap_fill_reg;
        if (gap_push)
        begin
            gap_tail_next = (gap_tail_reg == GAP_LAST) ? '0 : gap_tail_reg + 1'b1;
            gap_fill_next = gap_fill_reg + 1'b1;
        end
        if (gap_pop)
        begin
            gap_head_next = (gap_head_reg == GAP_LAST) ? '0 : gap_head_reg + 1'b1;
            gap_fill_next = gap_fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= trr_pkg::ST_IDLE;
            last_rel_reg   <= '0;
            full_reg       <= '0;
            missed_reg     <= '0;
            eof_reg        <= 1'b0;
            fin_idx_reg    <= '0;
            fin_tot_reg    <= '0;
            finished_reg   <= 1'b0;
            held_valid_reg <= '0;
            gap_head_reg   <= '0;
            gap_tail_reg   <= '0;
            gap_fill_reg   <= '0;
            scan_ptr_reg   <= '0;
            best_v_reg     <= 1'b0;
            pend_v_reg     <= 1'b0;
            out_v_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            last_rel_reg   <= last_rel_next;
            full_reg       <= full_next;
            missed_reg     <= missed_next;
            eof_reg        <= eof_next;
            fin_idx_reg    <= fin_idx_next;
            fin_tot_reg    <= fin_tot_next;
            finished_reg   <= finished_next;
            held_valid_reg <= held_valid_next;
            gap_head_reg   <= gap_head_next;
            gap_tail_reg   <= gap_tail_next;
            gap_fill_reg   <= gap_fill_next;
            scan_ptr_reg   <= scan_ptr_next;
            best_v_reg     <= best_v_next;
            pend_v_reg     <= pend_v_next;
            out_v_reg      <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        best_idx_reg  <= best_idx_next;
        best_slot_reg <= best_slot_next;
        pend_reg      <= pend_next;
        out_reg       <= out_next;
        out_last_reg  <= out_last_next;
        if (hold_wr)
        begin
            held_index_reg[free_slot] <= item_reg.ts_index;
            held_tag_reg[free_slot]   <= item_reg.payload_tag;
        end
        if (gap_push)
        begin
            gap_mem_reg[gap_tail_reg] <= item_reg.ts_index;
        end
    end

endmodule
